FILE: rtl/hqs_pkg.sv
// Package for the hybrid quicksort engine: sequencer states, stack control
// struct and shared constants. No dependencies.
package hqs_pkg;

    localparam int DATA_W          = 32;
    localparam int CUT_W           = 6;
    localparam int DEPTH_DEF       = 64;
    localparam int STACK_DEPTH_DEF = 8;

    localparam logic [CUT_W-1:0] CUTOFF_RESET = 6'd10;
    localparam logic [CUT_W-1:0] CUTOFF_MIN   = 6'd3;

    typedef enum logic [4:0] {
        S_LOAD,
        S_CHECK,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_JDEC,
        S_JCHK,
        S_IINC,
        S_ICHK,
        S_CMP,
        S_SW2,
        S_FIN,
        S_FIN2,
        S_INS_K,
        S_INS_KEY,
        S_INS_CMP,
        S_INS_PUT,
        S_POP,
        S_ERD,
        S_EOUT
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

FILE: rtl/hybrid_quicksort_engine.sv
// Top level of the hybrid quicksort engine: load store, quicksort sequencer,
// insertion sort and emit. Depends on hqs_pkg and hqs_range_stack.
//
// Usage:
//  Slave stream (s_axis): one 32-bit word per accepted beat is written to the
//  sort store. tlast marks the last word of a data set; a full store (DEPTH
//  words) starts the sort as well. Load accepts one word per cycle.
//  After the closing word the block drops tready and sorts in place:
//  median-of-three quicksort with an explicit range stack, insertion sort for
//  spans at or below the cutoff register and for split parts that find the
//  stack full. All steps go through one memory read port and one write port,
//  one access per cycle. A split reads lo, mid and hi, writes the median to
//  lo as pivot, then scans from both ends and swaps; insertion sort reads
//  each key and shifts larger words up; the sort is quadratic at worst.
//  Master stream (m_axis): the sorted run, ascending; each word is read
//  from the store, then registered out; tlast on the last word. A stalled
//  receiver holds the output register and pauses the emit. The next load
//  starts while the last sorted word still waits.
//  Config: i_cfg_we writes insertion_cutoff (values below 3 act as 3); write
//  only while idle.
//  Reset: synchronous, active low; clears the count, stack and output valid,
//  cutoff returns to 10. Store contents are not cleared.
module hybrid_quicksort_engine #(
    parameter int DEPTH       = hqs_pkg::DEPTH_DEF,
    parameter int STACK_DEPTH = hqs_pkg::STACK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [hqs_pkg::DATA_W-1:0] i_s_axis_tdata,  // [31:0] value
    input  logic                       i_s_axis_tlast,  // final_item
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [hqs_pkg::DATA_W-1:0] o_m_axis_tdata,  // [31:0] sorted_value
    output logic                       o_m_axis_tlast,  // run_end
    input  logic                       i_cfg_we,
    input  logic [hqs_pkg::CUT_W-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = AW + 2;
    localparam int CW = (IW > 8) ? IW : 8;
    localparam int DW = hqs_pkg::DATA_W;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd;

    hqs_pkg::t_state r_state, n_state;

    logic signed [IW-1:0] r_lo, n_lo, r_hi, n_hi, r_i, n_i, r_j, n_j;
    logic signed [IW-1:0] r_k, n_k, r_c, n_c, r_ia, n_ia, r_ib, n_ib;
    logic [DW-1:0] r_pivot, n_pivot, r_va, n_va, r_vb, n_vb;
    logic [DW-1:0] r_vi, n_vi, r_vj, n_vj, r_key, n_key;
    logic          r_ret, n_ret;
    logic [AW-1:0] r_e, n_e;
    logic [AW:0]   r_n, n_n, r_count, n_count;
    logic [hqs_pkg::CUT_W-1:0] r_cut;
    logic [DW-1:0] r_out, n_out;
    logic          r_ovalid, n_ovalid, r_olast, n_olast;

    logic signed [IW-1:0] w_ra, w_wa, w_mid, w_plo, w_phi, w_pick;
    logic [DW-1:0]        w_wd, w_pv, w_vs, w_vbg;
    logic signed [IW-1:0] w_is, w_ib;
    logic                 w_we;
    logic signed [CW-1:0] w_span, w_cut;
    logic [hqs_pkg::CUT_W-1:0] w_cut_eff;

    hqs_pkg::t_stk_ctl w_stk;
    logic [AW-1:0] w_stk_lo, w_stk_hi;
    logic          w_stk_empty, w_stk_full;

    hqs_range_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_stk),
        .i_lo    (w_plo[AW-1:0]),
        .i_hi    (w_phi[AW-1:0]),
        .o_lo    (w_stk_lo),
        .o_hi    (w_stk_hi),
        .o_empty (w_stk_empty),
        .o_full  (w_stk_full)
    );

    assign o_s_axis_tready = (r_state == hqs_pkg::S_LOAD);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out;
    assign o_m_axis_tlast  = r_olast;

    assign w_cut_eff = (r_cut < hqs_pkg::CUTOFF_MIN) ? hqs_pkg::CUTOFF_MIN : r_cut;
    assign w_cut     = signed'(CW'(w_cut_eff));
    assign w_span    = CW'(r_hi - r_lo);
    assign w_mid     = (r_lo + r_hi) >>> 1;

    // split: larger part goes to the stack, smaller stays current (on a tie the upper part goes to the stack)
    always_comb begin
        if ((r_hi - r_j) < (r_j - r_lo)) begin
            w_plo = r_lo;
            w_phi = r_j - IW'(1);
        end else begin
            w_plo = r_j + IW'(1);
            w_phi = r_hi;
        end
    end

    // median of three over lo, mid, hi (r_rd holds the hi word in S_M3)
    always_comb begin
        if (r_va < r_vb) begin
            w_is = r_lo;  w_vs = r_va;
            w_ib = w_mid; w_vbg = r_vb;
        end else begin
            w_is = w_mid; w_vs = r_vb;
            w_ib = r_lo;  w_vbg = r_va;
        end
        if (r_rd <= w_vs) begin
            w_pick = w_is; w_pv = w_vs;
        end else if (r_rd <= w_vbg) begin
            w_pick = r_hi; w_pv = r_rd;
        end else begin
            w_pick = w_ib; w_pv = w_vbg;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_c      = r_c;
        n_ia     = r_ia;
        n_ib     = r_ib;
        n_pivot  = r_pivot;
        n_va     = r_va;
        n_vb     = r_vb;
        n_vi     = r_vi;
        n_vj     = r_vj;
        n_key    = r_key;
        n_ret    = r_ret;
        n_e      = r_e;
        n_n      = r_n;
        n_count  = r_count;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_olast  = r_olast;
        w_ra     = '0;
        w_we     = 1'b0;
        w_wa     = '0;
        w_wd     = '0;
        w_stk    = '0;

        unique case (r_state) inside
            hqs_pkg::S_LOAD: begin
                if (i_s_axis_tvalid) begin
                    w_we    = 1'b1;
                    w_wa    = signed'(IW'(r_count));
                    w_wd    = i_s_axis_tdata;
                    n_count = r_count + (AW+1)'(1);
                    if (i_s_axis_tlast || (r_count + (AW+1)'(1) == (AW+1)'(DEPTH))) begin
                        n_n     = r_count + (AW+1)'(1);
                        n_lo    = '0;
                        n_hi    = signed'(IW'(r_count));
                        n_state = hqs_pkg::S_CHECK;
                    end
                end
            end
            hqs_pkg::S_CHECK: begin
                if (w_span <= w_cut) begin
                    n_ia    = r_lo;
                    n_ib    = r_hi;
                    n_k     = r_lo + IW'(1);
                    n_ret   = 1'b0;
                    n_state = hqs_pkg::S_INS_K;
                end else begin
                    w_ra    = r_lo;
                    n_state = hqs_pkg::S_M1;
                end
            end
            hqs_pkg::S_M1: begin
                n_va    = r_rd;
                w_ra    = w_mid;
                n_state = hqs_pkg::S_M2;
            end
            hqs_pkg::S_M2: begin
                n_vb    = r_rd;
                w_ra    = r_hi;
                n_state = hqs_pkg::S_M3;
            end
            hqs_pkg::S_M3: begin
                n_pivot = w_pv;
                w_we    = 1'b1;
                w_wa    = w_pick;
                w_wd    = r_va;
                n_state = hqs_pkg::S_M4;
            end
            hqs_pkg::S_M4: begin
                w_we    = 1'b1;
                w_wa    = r_lo;
                w_wd    = r_pivot;
                n_i     = r_lo;
                n_j     = r_hi + IW'(1);
                n_state = hqs_pkg::S_JDEC;
            end
            hqs_pkg::S_JDEC: begin
                n_j     = r_j - IW'(1);
                w_ra    = r_j - IW'(1);
                n_state = hqs_pkg::S_JCHK;
            end
            hqs_pkg::S_JCHK: begin
                // pivot sits at lo, so this scan always stops there
                if (r_rd > r_pivot) begin
                    n_j  = r_j - IW'(1);
                    w_ra = r_j - IW'(1);
                end else begin
                    n_vj    = r_rd;
                    n_state = hqs_pkg::S_IINC;
                end
            end
            hqs_pkg::S_IINC, hqs_pkg::S_ICHK: begin
                if (r_state == hqs_pkg::S_ICHK && !(r_rd < r_pivot)) begin
                    n_vi    = r_rd;
                    n_state = hqs_pkg::S_CMP;
                end else if (r_i + IW'(1) > r_hi) begin
                    n_i     = r_hi + IW'(1);
                    n_state = hqs_pkg::S_CMP;
                end else begin
                    n_i     = r_i + IW'(1);
                    w_ra    = r_i + IW'(1);
                    n_state = hqs_pkg::S_ICHK;
                end
            end
            hqs_pkg::S_CMP: begin
                if (r_i >= r_j) begin
                    n_state = hqs_pkg::S_FIN;
                end else begin
                    w_we    = 1'b1;
                    w_wa    = r_i;
                    w_wd    = r_vj;
                    n_state = hqs_pkg::S_SW2;
                end
            end
            hqs_pkg::S_SW2: begin
                w_we    = 1'b1;
                w_wa    = r_j;
                w_wd    = r_vi;
                n_state = hqs_pkg::S_JDEC;
            end
            hqs_pkg::S_FIN: begin
                w_we    = 1'b1;
                w_wa    = r_lo;
                w_wd    = r_vj;
                n_state = hqs_pkg::S_FIN2;
            end
            hqs_pkg::S_FIN2: begin
                w_we    = 1'b1;
                w_wa    = r_j;
                w_wd    = r_pivot;
                n_state = hqs_pkg::S_CHECK;
                if ((r_hi - r_j) < (r_j - r_lo)) begin
                    n_lo = r_j + IW'(1);
                end else begin
                    n_hi = r_j - IW'(1);
                end
                if (w_phi > w_plo) begin
                    if (w_stk_full) begin
                        n_ia    = w_plo;
                        n_ib    = w_phi;
                        n_k     = w_plo + IW'(1);
                        n_ret   = 1'b1;
                        n_state = hqs_pkg::S_INS_K;
                    end else begin
                        w_stk.push = 1'b1;
                    end
                end
            end
            hqs_pkg::S_INS_K: begin
                if (r_k > r_ib) begin
                    n_state = r_ret ? hqs_pkg::S_CHECK : hqs_pkg::S_POP;
                end else begin
                    w_ra    = r_k;
                    n_state = hqs_pkg::S_INS_KEY;
                end
            end
            hqs_pkg::S_INS_KEY: begin
                n_key   = r_rd;
                n_c     = r_k;
                w_ra    = r_k - IW'(1);
                n_state = hqs_pkg::S_INS_CMP;
            end
            hqs_pkg::S_INS_CMP: begin
                if (r_rd > r_key) begin
                    w_we = 1'b1;
                    w_wa = r_c;
                    w_wd = r_rd;
                    n_c  = r_c - IW'(1);
                    if (r_c - IW'(1) > r_ia) begin
                        w_ra = r_c - IW'(2);
                    end else begin
                        n_state = hqs_pkg::S_INS_PUT;
                    end
                end else begin
                    n_state = hqs_pkg::S_INS_PUT;
                end
            end
            hqs_pkg::S_INS_PUT: begin
                w_we    = 1'b1;
                w_wa    = r_c;
                w_wd    = r_key;
                n_k     = r_k + IW'(1);
                n_state = hqs_pkg::S_INS_K;
            end
            hqs_pkg::S_POP: begin
                if (w_stk_empty) begin
                    n_e     = '0;
                    n_state = hqs_pkg::S_ERD;
                end else begin
                    w_stk.pop = 1'b1;
                    n_lo      = signed'(IW'(w_stk_lo));
                    n_hi      = signed'(IW'(w_stk_hi));
                    n_state   = hqs_pkg::S_CHECK;
                end
            end
            hqs_pkg::S_ERD: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    w_ra    = signed'(IW'(r_e));
                    n_state = hqs_pkg::S_EOUT;
                end
            end
            hqs_pkg::S_EOUT: begin
                n_out    = r_rd;
                n_ovalid = 1'b1;
                n_olast  = ((AW+1)'(r_e) == r_n - (AW+1)'(1));
                if ((AW+1)'(r_e) == r_n - (AW+1)'(1)) begin
                    n_count = '0;
                    n_state = hqs_pkg::S_LOAD;
                end else begin
                    n_e     = r_e + AW'(1);
                    n_state = hqs_pkg::S_ERD;
                end
            end
            default: n_state = hqs_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa[AW-1:0]] <= w_wd;
        end
        r_rd <= mem[w_ra[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hqs_pkg::S_LOAD;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_cut    <= hqs_pkg::CUTOFF_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_cut <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_c     <= n_c;
        r_ia    <= n_ia;
        r_ib    <= n_ib;
        r_pivot <= n_pivot;
        r_va    <= n_va;
        r_vb    <= n_vb;
        r_vi    <= n_vi;
        r_vj    <= n_vj;
        r_key   <= n_key;
        r_ret   <= n_ret;
        r_e     <= n_e;
        r_n     <= n_n;
        r_out   <= n_out;
        r_olast <= n_olast;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (r_count < (AW+1)'(DEPTH)))
        else $error("load count reached store depth while loading");
    a_jscan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hqs_pkg::S_JCHK) |-> (r_j >= r_lo))
        else $error("downward split scan passed range start");
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hqs_pkg::S_EOUT && n_olast) |=>
            (o_s_axis_tready && r_count == '0 && o_m_axis_tvalid && o_m_axis_tlast))
        else $error("run end did not return block to loading");
`endif

endmodule

FILE: rtl/hqs_range_stack.sv
// Bounded stack of pending sort ranges (first/last index pairs).
// Depends on hqs_pkg for the control struct.
module hqs_range_stack #(
    parameter int STACK_DEPTH = hqs_pkg::STACK_DEPTH_DEF,
    parameter int AW          = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hqs_pkg::t_stk_ctl i_ctl,
    input  logic [AW-1:0]     i_lo,
    input  logic [AW-1:0]     i_hi,
    output logic [AW-1:0]     o_lo,
    output logic [AW-1:0]     o_hi,
    output logic              o_empty,
    output logic              o_full
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $clog2(STACK_DEPTH);

    logic [AW-1:0] r_lo_a [STACK_DEPTH];
    logic [AW-1:0] r_hi_a [STACK_DEPTH];
    logic [LW-1:0] r_lvl;
    logic [LW-1:0] n_lvl;
    logic [LW-1:0] w_top;

    assign w_top   = r_lvl - LW'(1);
    assign o_lo    = r_lo_a[w_top[PW-1:0]];
    assign o_hi    = r_hi_a[w_top[PW-1:0]];
    assign o_empty = (r_lvl == '0);
    assign o_full  = (r_lvl == LW'(STACK_DEPTH));

    always_comb begin
        n_lvl = r_lvl;
        if (i_ctl.push) begin
            n_lvl = r_lvl + LW'(1);
        end else if (i_ctl.pop) begin
            n_lvl = r_lvl - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
        end else begin
            r_lvl <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_lo_a[r_lvl[PW-1:0]] <= i_lo;
            r_hi_a[r_lvl[PW-1:0]] <= i_hi;
        end
    end

`ifndef SYNTH
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_full) else $error("push on full range stack");
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_empty) else $error("pop on empty range stack");
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= LW'(STACK_DEPTH)) else $error("stack level out of range");
`endif

endmodule

FILE: dv/hybrid_quicksort_engine_tb.sv
// Testbench for hybrid_quicksort_engine: streams data sets in, checks the sorted
// runs word by word against an in-bench quicksort predictor. Depends on hqs_pkg.
module hybrid_quicksort_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 64;
    localparam int STACK_DEPTH = 8;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DATA_W      = hqs_pkg::DATA_W;
    localparam int CUT_W       = hqs_pkg::CUT_W;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } t_load_word;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              run_end;
    } t_sorted_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [DATA_W-1:0] i_s_axis_tdata = '0;
    logic              i_s_axis_tlast = 1'b0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0] o_m_axis_tdata;
    logic              o_m_axis_tlast;
    logic              i_cfg_we;
    logic [CUT_W-1:0]  i_cfg_wdata;

    hybrid_quicksort_engine #(.DEPTH(DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // predictor state
    logic [DATA_W-1:0] pred_store [DEPTH];
    int                pred_count = 0;
    logic [CUT_W-1:0]  pred_cutoff;

    t_load_word   load_queue [$];
    t_sorted_word sorted_queue [$];

    int  error_count = 0;
    int  words_loaded = 0;
    int  words_sorted = 0;
    int  runs_seen = 0;
    int  cycle_count = 0;
    bit  idle_enable;
    int  tx_gap = 0;
    int  rx_gap = 0;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch %s: got %h expected %h (word %0d)", what, got, want, words_sorted);
        error_count++;
    endtask

    function automatic void swap_pred(input int a, input int b);
        logic [DATA_W-1:0] t;
        t = pred_store[a];
        pred_store[a] = pred_store[b];
        pred_store[b] = t;
    endfunction

    function automatic void insertion_pass(input int lo, input int hi);
        logic [DATA_W-1:0] key;
        int c;
        for (int k = lo + 1; k <= hi; k++) begin
            key = pred_store[k];
            c = k;
            while (c > lo && pred_store[c-1] > key) begin
                pred_store[c] = pred_store[c-1];
                c--;
            end
            pred_store[c] = key;
        end
    endfunction

    function automatic int split_range(input int lo, input int hi);
        int mid, lesser, greater, pick, i, j;
        logic [DATA_W-1:0] pivot;
        mid = (lo + hi) / 2;
        if (pred_store[lo] < pred_store[mid]) begin
            lesser = lo; greater = mid;
        end else begin
            lesser = mid; greater = lo;
        end
        if (pred_store[hi] <= pred_store[lesser]) pick = lesser;
        else if (pred_store[hi] <= pred_store[greater]) pick = hi;
        else pick = greater;
        swap_pred(pick, lo);
        pivot = pred_store[lo];
        i = lo;
        j = hi + 1;
        forever begin
            do j--; while (pred_store[j] > pivot);
            do i++; while (i <= hi && pred_store[i] < pivot);
            if (i >= j) break;
            swap_pred(i, j);
        end
        swap_pred(lo, j);
        return j;
    endfunction

    function automatic void sort_pred(input int n);
        int stk_lo [STACK_DEPTH];
        int stk_hi [STACK_DEPTH];
        int level, lo, hi, sp, plo, phi, cut;
        cut = (pred_cutoff < hqs_pkg::CUTOFF_MIN) ? int'(hqs_pkg::CUTOFF_MIN)
                                                   : int'(pred_cutoff);
        stk_lo[0] = 0;
        stk_hi[0] = n - 1;
        level = 1;
        while (level > 0) begin
            level--;
            lo = stk_lo[level];
            hi = stk_hi[level];
            forever begin
                if (hi - lo <= cut) begin
                    insertion_pass(lo, hi);
                    break;
                end
                sp = split_range(lo, hi);
                if (hi - sp < sp - lo) begin
                    plo = lo; phi = sp - 1; lo = sp + 1;
                end else begin
                    plo = sp + 1; phi = hi; hi = sp - 1;
                end
                if (phi > plo) begin
                    if (level >= STACK_DEPTH) insertion_pass(plo, phi);
                    else begin
                        stk_lo[level] = plo;
                        stk_hi[level] = phi;
                        level++;
                    end
                end
            end
        end
    endfunction

    // called per accepted load word
    function automatic void predict_load(input t_load_word w);
        t_sorted_word r;
        if (pred_count >= DEPTH) pred_count = 0;
        pred_store[pred_count] = w.value;
        pred_count++;
        if (!w.last && pred_count < DEPTH) return;
        sort_pred(pred_count);
        for (int k = 0; k < pred_count; k++) begin
            r.value = pred_store[k];
            r.run_end = (k == pred_count - 1);
            sorted_queue.push_back(r);
        end
        pred_count = 0;
    endfunction

    function automatic logic [DATA_W-1:0] rand_value(input int style);
        case (style)
            0: return $urandom_range(0, 7);
            1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
            2: return $urandom_range(0, 3) << 30;
            default: return $urandom;
        endcase
    endfunction

    // n words, last one flagged unless it fills the store
    task automatic queue_set(input int n, input int style);
        t_load_word w;
        logic [DATA_W-1:0] base;
        base = $urandom;
        for (int k = 0; k < n; k++) begin
            case (style)
                4: w.value = base + k;
                5: w.value = base - k;
                6: w.value = base;
                default: w.value = rand_value(style);
            endcase
            w.last = (k == n - 1) && (n < DEPTH);
            load_queue.push_back(w);
        end
    endtask

    task automatic wait_drained();
        while (load_queue.size() > 0 || i_s_axis_tvalid || sorted_queue.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cutoff(input logic [CUT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pred_cutoff = val;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !o_s_axis_tready) begin
            // hold
        end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            i_s_axis_tvalid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 15) == 0) begin
            tx_gap <= $urandom_range(0, 14);
            i_s_axis_tvalid <= 1'b0;
        end else if (load_queue.size() > 0) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata <= load_queue[0].value;
            i_s_axis_tlast <= load_queue[0].last;
            void'(load_queue.pop_front());
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 14);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_load_word   lw;
        t_sorted_word want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            lw.value = i_s_axis_tdata;
            lw.last = i_s_axis_tlast;
            predict_load(lw);
            words_loaded <= words_loaded + 1;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (sorted_queue.size() == 0) begin
                report_mismatch("unexpected word", o_m_axis_tdata, '0);
            end else begin
                want = sorted_queue.pop_front();
                if (o_m_axis_tdata !== want.value)
                    report_mismatch("value", o_m_axis_tdata, want.value);
                if (o_m_axis_tlast !== want.run_end)
                    report_mismatch("tlast", DATA_W'(o_m_axis_tlast),
                                    DATA_W'(want.run_end));
                if (want.run_end) runs_seen <= runs_seen + 1;
            end
            words_sorted <= words_sorted + 1;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [CUT_W-1:0] cut_list [6];
        cut_list = '{6'd3, 6'd32, 6'd0, 6'd63, 6'd5, 6'd10};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        idle_enable = 1'b1;
        pred_cutoff = hqs_pkg::CUTOFF_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single word, a pair, extremes, sorted/reversed/equal, full store
        queue_set(1, 3);
        queue_set(2, 1);
        load_queue.push_back('{value: 32'hFFFF_FFFF, last: 1'b0});
        load_queue.push_back('{value: 32'h0000_0000, last: 1'b0});
        load_queue.push_back('{value: 32'h8000_0000, last: 1'b0});
        load_queue.push_back('{value: 32'h7FFF_FFFF, last: 1'b1});
        queue_set(5, 0);
        queue_set(3, 6);
        queue_set(8, 5);
        wait_drained();
        queue_set(DEPTH, 5);   // fills store, no tlast
        queue_set(40, 4);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            write_cutoff(cut_list[p]);
            if (p == 5) idle_enable = 1'b0;
            for (int s = 0; s < 3; s++) begin
                if ($urandom_range(0, 9) == 0) queue_set(DEPTH, $urandom_range(0, 6));
                else queue_set($urandom_range(1, 24), $urandom_range(0, 6));
            end
            wait_drained();
        end

        $display("loaded %0d words, checked %0d sorted words in %0d runs",
                 words_loaded, words_sorted, runs_seen);
        $display("cutoffs 0, 3, 5, 10, 32, 63; sets from 1 word to a full store");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/hqs_pkg.sv
rtl/hqs_range_stack.sv
rtl/hybrid_quicksort_engine.sv
dv/hybrid_quicksort_engine_tb.sv
